// ===== rtl/hfd_pkg.sv =====
`timescale 1ns / 1ps
// hfd_pkg: shared types, codes and defaults for the heartbeat failure detector
// no dependencies; used by heartbeat_failure_detector

package hfd_pkg;

    // default sizes
    localparam int NUM_NODES_DEF   = 16;
    localparam int STAMP_WIDTH_DEF = 32;

    // field widths fixed by the interface
    localparam int OP_W      = 2;
    localparam int NODE_W    = 4;
    localparam int EVENT_W   = 2;
    localparam int MASK_W    = 16;
    localparam int TIMEOUT_W = 20;
    localparam int PHASE_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEER_MASK        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEND_INTERVAL    = 2'd3;

    // configuration reset values
    localparam logic [MASK_W-1:0]    PEER_MASK_RST        = 16'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST    = 20'd3000;
    localparam logic [PHASE_W-1:0]   MONITOR_INTERVAL_RST = 16'd1000;
    localparam logic [PHASE_W-1:0]   SEND_INTERVAL_RST    = 16'd1000;

    typedef enum logic [OP_W-1:0] {
        OP_START     = 2'd0,
        OP_HEARTBEAT = 2'd1,
        OP_TICK      = 2'd2,
        OP_QUERY     = 2'd3
    } hfd_op_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE      = 2'd0,
        EV_RECOVERED = 2'd1,
        EV_FAILED    = 2'd2
    } hfd_event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_TAIL,
        ST_FLUSH,
        ST_QUERY
    } hfd_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NODE_W-1:0] node;
    } hfd_req_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [NODE_W-1:0]  event_node;
        logic               node_alive;
        logic [MASK_W-1:0]  alive_mask;
        logic               send_beat;
        logic               last;
    } hfd_res_t;

endpackage

// ===== rtl/heartbeat_failure_detector.sv =====
`timescale 1ns / 1ps
// heartbeat_failure_detector: peer liveness watchdog, stamps kept in one memory
// depends on hfd_pkg

// usage
//   request channel: drive req and pulse start; a request is taken at an edge
//   with start high and busy low. busy is high for start, query and scan ticks.
//   result channel: done is high for exactly one cycle per result, with the
//   result on the result port; result.last marks the final result of a request.
//   the receiver cannot stall, so results are never held back.
//   config port: cfg_we/cfg_idx/cfg_wdata write one register per edge; write
//   only while the block is idle, the block itself does not enforce it.
// request flow
//   heartbeat: result registered at acceptance, busy stays low throughout.
//   query: one stamp read, then the result is registered in ST_QUERY.
//   start: ST_FILL restamps each peer-mask node, result at the end.
//   tick without scan: result registered directly. tick with scan: the stamp
//   memory is read one node per cycle in ST_SCAN, then ST_TAIL and ST_FLUSH,
//   with at most one failure result per cycle.
// reset
//   control state clears, config registers take defaults; the stamp memory is
//   not cleared, a node is stamped by the heartbeat or start fill that tracks it.

module heartbeat_failure_detector #(
    parameter int NUM_NODES   = hfd_pkg::NUM_NODES_DEF,
    parameter int STAMP_WIDTH = hfd_pkg::STAMP_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  hfd_pkg::hfd_req_t                    req,
    output logic                                 done,
    output hfd_pkg::hfd_res_t                    result,
    input  logic                                 cfg_we,
    input  logic [hfd_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [hfd_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    import hfd_pkg::*;

    localparam int IDX_W      = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int NODE_EXT_W = ((NODE_W > IDX_W) ? NODE_W : IDX_W) + 1;
    localparam int CMP_W      = (STAMP_WIDTH > TIMEOUT_W) ? STAMP_WIDTH : TIMEOUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_NODES - 1);

    // configuration registers
    logic [MASK_W-1:0]    peer_mask_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [PHASE_W-1:0]   mon_int_reg;
    logic [PHASE_W-1:0]   send_int_reg;

    // control state
    hfd_state_t              state_reg, state_next;
    logic [STAMP_WIDTH-1:0]  time_reg, time_next;
    logic [NUM_NODES-1:0]    tracked_reg, tracked_next;
    logic [NUM_NODES-1:0]    alive_reg, alive_next;
    logic [PHASE_W-1:0]      mon_phase_reg, mon_phase_next;
    logic [PHASE_W-1:0]      send_phase_reg, send_phase_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    beat_reg, beat_next;
    logic                    qry_ok_reg, qry_ok_next;

    // held failure, sent once the next one is found or the scan ends
    logic                    pend_vld_reg, pend_vld_next;
    logic [NODE_W-1:0]       pend_node_reg, pend_node_next;
    logic [MASK_W-1:0]       pend_mask_reg, pend_mask_next;

    // scan compare stage, aligned with the memory read data
    logic                    eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]        eval_idx_reg, eval_idx_next;

    // result register
    logic                    res_vld_reg, res_vld_next;
    hfd_res_t                res_reg, res_next;

    // stamp memory
    logic [STAMP_WIDTH-1:0]  stamp_mem [NUM_NODES];
    logic [STAMP_WIDTH-1:0]  rdata_reg;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [STAMP_WIDTH-1:0]  wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;

    // request decode
    logic                    accept;
    logic [NODE_EXT_W-1:0]   node_ext;
    logic                    node_ok;
    logic [IDX_W-1:0]        node_idx;
    logic [NUM_NODES-1:0]    peer_nodes;

    // age check on the stamp just read
    logic [STAMP_WIDTH-1:0]  age;
    logic                    expired;
    logic                    eval_fail;

    function automatic logic [MASK_W-1:0] to_mask(input logic [NUM_NODES-1:0] v);
        logic [NUM_NODES+MASK_W-1:0] p;
        p = {{MASK_W{1'b0}}, v};
        return p[MASK_W-1:0];
    endfunction

    function automatic logic [NUM_NODES-1:0] to_nodes(input logic [MASK_W-1:0] v);
        logic [NUM_NODES+MASK_W-1:0] p;
        p = {{NUM_NODES{1'b0}}, v};
        return p[NUM_NODES-1:0];
    endfunction

    function automatic logic [NODE_W-1:0] to_node(input logic [IDX_W-1:0] v);
        logic [NODE_W+IDX_W-1:0] p;
        p = {{NODE_W{1'b0}}, v};
        return p[NODE_W-1:0];
    endfunction

    function automatic hfd_res_t mk_res(
        input hfd_event_t        ev,
        input logic [NODE_W-1:0] nd,
        input logic              alive,
        input logic [MASK_W-1:0] mask,
        input logic              beat,
        input logic              last
    );
        hfd_res_t r;
        r.event_res  = ev;
        r.event_node = nd;
        r.node_alive = alive;
        r.alive_mask = mask;
        r.send_beat  = beat;
        r.last       = last;
        return r;
    endfunction

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign done   = res_vld_reg;
    assign result = res_reg;

    // node index, out-of-range nodes are ignored
    assign node_ext   = NODE_EXT_W'(req.node);
    assign node_ok    = (node_ext < NODE_EXT_W'(NUM_NODES));
    assign node_idx   = node_ext[IDX_W-1:0];
    assign peer_nodes = to_nodes(peer_mask_reg);

    // ages wrap with the tick counter
    assign age       = time_reg - rdata_reg;
    assign expired   = (CMP_W'(age) >= CMP_W'(timeout_reg));
    assign eval_fail = eval_vld_reg && tracked_reg[eval_idx_reg]
                       && alive_reg[eval_idx_reg] && expired;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_mask_reg <= PEER_MASK_RST;
            timeout_reg   <= TIMEOUT_TICKS_RST;
            mon_int_reg   <= MONITOR_INTERVAL_RST;
            send_int_reg  <= SEND_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_PEER_MASK:        peer_mask_reg <= cfg_wdata[MASK_W-1:0];
                CFG_TIMEOUT_TICKS:    timeout_reg   <= cfg_wdata[TIMEOUT_W-1:0];
                CFG_MONITOR_INTERVAL: mon_int_reg   <= cfg_wdata[PHASE_W-1:0];
                CFG_SEND_INTERVAL:    send_int_reg  <= cfg_wdata[PHASE_W-1:0];
                default:              ;
            endcase
        end
    end

    // stamp memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= stamp_mem[rd_addr];
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            tracked_reg    <= '0;
            alive_reg      <= '0;
            mon_phase_reg  <= '0;
            send_phase_reg <= '0;
            idx_reg        <= '0;
            beat_reg       <= 1'b0;
            qry_ok_reg     <= 1'b0;
            pend_vld_reg   <= 1'b0;
            eval_vld_reg   <= 1'b0;
            eval_idx_reg   <= '0;
            res_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            tracked_reg    <= tracked_next;
            alive_reg      <= alive_next;
            mon_phase_reg  <= mon_phase_next;
            send_phase_reg <= send_phase_next;
            idx_reg        <= idx_next;
            beat_reg       <= beat_next;
            qry_ok_reg     <= qry_ok_next;
            pend_vld_reg   <= pend_vld_next;
            eval_vld_reg   <= eval_vld_next;
            eval_idx_reg   <= eval_idx_next;
            res_vld_reg    <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_node_reg <= pend_node_next;
        pend_mask_reg <= pend_mask_next;
        res_reg       <= res_next;
    end

    // next state and datapath control
    always_comb
    begin
        logic [PHASE_W-1:0]   sp_inc;
        logic [PHASE_W-1:0]   mp_inc;
        logic                 beat_v;
        logic [NUM_NODES-1:0] bit_v;
        hfd_event_t           ev_v;

        state_next      = state_reg;
        time_next       = time_reg;
        tracked_next    = tracked_reg;
        alive_next      = alive_reg;
        mon_phase_next  = mon_phase_reg;
        send_phase_next = send_phase_reg;
        idx_next        = idx_reg;
        beat_next       = beat_reg;
        qry_ok_next     = qry_ok_reg;
        pend_vld_next   = pend_vld_reg;
        pend_node_next  = pend_node_reg;
        pend_mask_next  = pend_mask_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = idx_reg;
        res_vld_next    = 1'b0;
        res_next        = res_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = time_reg;
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        sp_inc          = send_phase_reg + 1'b1;
        mp_inc          = mon_phase_reg + 1'b1;
        beat_v          = 1'b0;
        bit_v           = '0;
        ev_v            = EV_NONE;

        // scan compare: a new failure releases the one held before it
        if (eval_fail)
        begin
            bit_v                    = '0;
            bit_v[eval_idx_reg]      = 1'b1;
            alive_next               = alive_reg & ~bit_v;
            if (pend_vld_reg)
            begin
                res_vld_next = 1'b1;
                res_next     = mk_res(EV_FAILED, pend_node_reg, 1'b0, pend_mask_reg,
                                      beat_reg, 1'b0);
            end
            pend_vld_next  = 1'b1;
            pend_node_next = to_node(eval_idx_reg);
            pend_mask_next = to_mask(alive_next);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (hfd_op_t'(req.op))
                        OP_START:
                        begin
                            tracked_next    = tracked_reg | peer_nodes;
                            alive_next      = alive_reg | peer_nodes;
                            mon_phase_next  = '0;
                            send_phase_next = '0;
                            idx_next        = '0;
                            state_next      = ST_FILL;
                        end
                        OP_HEARTBEAT:
                        begin
                            if (node_ok)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = node_idx;
                                if (tracked_reg[node_idx] && !alive_reg[node_idx])
                                begin
                                    ev_v = EV_RECOVERED;
                                end
                                tracked_next[node_idx] = 1'b1;
                                alive_next[node_idx]   = 1'b1;
                            end
                            res_vld_next = 1'b1;
                            res_next     = mk_res(ev_v,
                                                  (ev_v == EV_RECOVERED) ? req.node : '0,
                                                  1'b0, to_mask(alive_next), 1'b0, 1'b1);
                        end
                        OP_TICK:
                        begin
                            time_next = time_reg + 1'b1;
                            if (sp_inc >= send_int_reg)
                            begin
                                send_phase_next = '0;
                                beat_v          = 1'b1;
                            end
                            else
                            begin
                                send_phase_next = sp_inc;
                            end
                            beat_next = beat_v;
                            if (mp_inc >= mon_int_reg)
                            begin
                                mon_phase_next = '0;
                                idx_next       = '0;
                                pend_vld_next  = 1'b0;
                                state_next     = ST_SCAN;
                            end
                            else
                            begin
                                mon_phase_next = mp_inc;
                                res_vld_next   = 1'b1;
                                res_next       = mk_res(EV_NONE, '0, 1'b0,
                                                        to_mask(alive_reg), beat_v, 1'b1);
                            end
                        end
                        OP_QUERY:
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = node_idx;
                            qry_ok_next = node_ok && tracked_reg[node_idx];
                            state_next  = ST_QUERY;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // restamp every node of the peer mask, one per cycle
            ST_FILL:
            begin
                wr_en   = peer_nodes[idx_reg];
                wr_addr = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    res_vld_next = 1'b1;
                    res_next     = mk_res(EV_NONE, '0, 1'b0, to_mask(alive_reg),
                                          1'b0, 1'b1);
                    state_next   = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // issue one stamp read per cycle, each compared in the cycle after
            ST_SCAN:
            begin
                rd_en         = 1'b1;
                rd_addr       = idx_reg;
                eval_vld_next = 1'b1;
                eval_idx_next = idx_reg;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // last node compares here
            ST_TAIL:
            begin
                state_next = ST_FLUSH;
            end

            // final result of the tick
            ST_FLUSH:
            begin
                res_vld_next = 1'b1;
                if (pend_vld_reg)
                begin
                    res_next = mk_res(EV_FAILED, pend_node_reg, 1'b0, pend_mask_reg,
                                      beat_reg, 1'b1);
                end
                else
                begin
                    res_next = mk_res(EV_NONE, '0, 1'b0, to_mask(alive_reg),
                                      beat_reg, 1'b1);
                end
                pend_vld_next = 1'b0;
                state_next    = ST_IDLE;
            end

            ST_QUERY:
            begin
                res_vld_next = 1'b1;
                res_next     = mk_res(EV_NONE, '0, qry_ok_reg && !expired,
                                      to_mask(alive_reg), 1'b0, 1'b1);
                state_next   = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for heartbeat_failure_detector, liveness predictor in-line
// depends on hfd_pkg and rtl/heartbeat_failure_detector.sv

module tb;
    import hfd_pkg::*;

    localparam int NODES   = NUM_NODES_DEF;
    localparam int STAMP_W = STAMP_WIDTH_DEF;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start = 1'b0;
    logic                  busy;
    hfd_req_t              req = '0;
    logic                  done;
    hfd_res_t              result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    heartbeat_failure_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // requests waiting to be driven, results still owed by the block
    hfd_req_t req_backlog [$];
    hfd_res_t liveness_exp_q [$];

    bit req_taken = 1'b0;   // set on the edge that takes a request
    bit steady    = 1'b0;   // no idle cycles on the request side
    int mismatch_cnt = 0;

    // predictor copy of the register file
    logic [MASK_W-1:0]    peer_mask_q = PEER_MASK_RST;
    logic [TIMEOUT_W-1:0] timeout_q   = TIMEOUT_TICKS_RST;
    logic [PHASE_W-1:0]   scan_iv     = MONITOR_INTERVAL_RST;
    logic [PHASE_W-1:0]   beat_iv     = SEND_INTERVAL_RST;

    // predictor copy of the liveness state
    logic [STAMP_W-1:0] clock_ticks = '0;
    logic [STAMP_W-1:0] stamp_q [NODES];
    logic [NODES-1:0]   tracked_q = '0;
    logic [NODES-1:0]   alive_q   = '0;
    logic [PHASE_W-1:0] scan_phase = '0;
    logic [PHASE_W-1:0] beat_phase = '0;

    // one result record; the alive mask is taken from the state as it is now
    function automatic hfd_res_t make_res(hfd_event_t ev, logic [NODE_W-1:0] nd,
                                          logic na, logic sb);
        hfd_res_t r;
        r.event_res  = ev;
        r.event_node = nd;
        r.node_alive = na;
        r.alive_mask = alive_q;
        r.send_beat  = sb;
        r.last       = 1'b0;
        return r;
    endfunction

    // advance the liveness state by one request and queue the results it owes
    function automatic void predict_liveness(hfd_req_t r);
        hfd_res_t           outs [NODES];
        int                 k;
        logic               beat;
        logic               ok;
        hfd_event_t         ev;
        logic [STAMP_W-1:0] age;
        k    = 0;
        beat = 1'b0;
        case (hfd_op_t'(r.op))
            OP_START:
            begin
                // restamp every peer, restart both interval counters
                for (int n = 0; n < NODES; n++)
                begin
                    if (peer_mask_q[n])
                        stamp_q[n] = clock_ticks;
                end
                tracked_q  |= peer_mask_q;
                alive_q    |= peer_mask_q;
                scan_phase  = '0;
                beat_phase  = '0;
                outs[k]     = make_res(EV_NONE, '0, 1'b0, 1'b0);
                k++;
            end
            OP_HEARTBEAT:
            begin
                // a tracked node that was declared dead comes back
                ev = (tracked_q[r.node] && !alive_q[r.node]) ? EV_RECOVERED : EV_NONE;
                stamp_q[r.node]   = clock_ticks;
                tracked_q[r.node] = 1'b1;
                alive_q[r.node]   = 1'b1;
                outs[k] = make_res(ev, (ev == EV_NONE) ? '0 : r.node, 1'b0, 1'b0);
                k++;
            end
            OP_TICK:
            begin
                clock_ticks = clock_ticks + 1'b1;
                beat_phase  = beat_phase + 1'b1;
                // an interval of zero behaves like one
                if (beat_phase >= beat_iv)
                begin
                    beat_phase = '0;
                    beat       = 1'b1;
                end
                scan_phase = scan_phase + 1'b1;
                if (scan_phase >= scan_iv)
                begin
                    scan_phase = '0;
                    // index order, one failure record per expired live node
                    for (int n = 0; n < NODES; n++)
                    begin
                        age = clock_ticks - stamp_q[n];
                        if (tracked_q[n] && alive_q[n] && age >= STAMP_W'(timeout_q))
                        begin
                            alive_q[n] = 1'b0;
                            outs[k]    = make_res(EV_FAILED, NODE_W'(n), 1'b0, beat);
                            k++;
                        end
                    end
                end
                if (k == 0)
                begin
                    outs[k] = make_res(EV_NONE, '0, 1'b0, beat);
                    k++;
                end
            end
            default:
            begin
                // query: tracked and younger than the timeout, regardless of the alive flag
                age = clock_ticks - stamp_q[r.node];
                ok  = tracked_q[r.node] && (age < STAMP_W'(timeout_q));
                outs[k] = make_res(EV_NONE, '0, ok, 1'b0);
                k++;
            end
        endcase
        for (int i = 0; i < k; i++)
        begin
            if (i == k - 1)
                outs[i].last = 1'b1;
            liveness_exp_q = {liveness_exp_q, outs[i]};
        end
    endfunction

    // request driver: changes on the falling edge, keeps start high across
    // back-to-back requests, and idles at random unless in a steady stretch
    always @(negedge clk)
    begin : drive_blk
        logic     nxt_start;
        hfd_req_t nxt_req;
        nxt_start = start;
        nxt_req   = req;
        if (rst_n)
        begin
            if (req_taken)
            begin
                nxt_start = 1'b0;
                req_taken = 1'b0;
            end
            if (!nxt_start && req_backlog.size() != 0 &&
                (steady || $urandom_range(0, 99) >= 9))
            begin
                nxt_req   = req_backlog.pop_front();
                nxt_start = 1'b1;
            end
        end
        start <= nxt_start;
        req   <= nxt_req;
    end

    // monitor: checks results, mirrors register writes, predicts taken requests
    always @(posedge clk)
    begin : watch_blk
        hfd_res_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (liveness_exp_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: unexpected result %h", $realtime, result);
                end
                else
                begin
                    want = liveness_exp_q.pop_front();
                    if (result.event_res  !== want.event_res  ||
                        result.event_node !== want.event_node ||
                        result.node_alive !== want.node_alive ||
                        result.alive_mask !== want.alive_mask ||
                        result.send_beat  !== want.send_beat  ||
                        result.last       !== want.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("%0t: mismatch exp ev=%0d nd=%0d alive=%0d mask=%h %s",
                                     $realtime, want.event_res, want.event_node,
                                     want.node_alive, want.alive_mask, "");
                            $display("    exp beat=%0d last=%0d", want.send_beat,
                                     want.last);
                            $display("    got ev=%0d nd=%0d alive=%0d mask=%h",
                                     result.event_res, result.event_node,
                                     result.node_alive, result.alive_mask);
                            $display("    got beat=%0d last=%0d", result.send_beat,
                                     result.last);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_PEER_MASK:        peer_mask_q = cfg_wdata[MASK_W-1:0];
                    CFG_TIMEOUT_TICKS:    timeout_q   = cfg_wdata[TIMEOUT_W-1:0];
                    CFG_MONITOR_INTERVAL: scan_iv     = cfg_wdata[PHASE_W-1:0];
                    CFG_SEND_INTERVAL:    beat_iv     = cfg_wdata[PHASE_W-1:0];
                    default:              ;
                endcase
            end
            if (start && !busy)
            begin
                predict_liveness(req);
                req_taken = 1'b1;
            end
        end
    end

    task automatic queue_item(hfd_op_t op, logic [NODE_W-1:0] nd);
        hfd_req_t r;
        r.op   = op;
        r.node = nd;
        req_backlog = {req_backlog, r};
    endtask

    // block until every request is taken and answered and the block is quiet
    task automatic settle();
        while (req_backlog.size() != 0 || start || liveness_exp_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_regs(logic [MASK_W-1:0] pm, logic [TIMEOUT_W-1:0] to,
                                logic [PHASE_W-1:0] mi, logic [PHASE_W-1:0] si);
        write_reg(CFG_PEER_MASK, CFG_DATA_W'(pm));
        write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(to));
        write_reg(CFG_MONITOR_INTERVAL, CFG_DATA_W'(mi));
        write_reg(CFG_SEND_INTERVAL, CFG_DATA_W'(si));
    endtask

    initial
    begin : stim_blk
        int pick;
        int burst;
        int n_left;
        logic [TIMEOUT_W-1:0] to;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: query of an untracked node, heartbeat adopts a node,
        // start with an empty peer mask
        queue_item(OP_QUERY, 4'd0);
        queue_item(OP_HEARTBEAT, 4'd15);
        queue_item(OP_QUERY, 4'd15);
        queue_item(OP_TICK, 4'd0);
        queue_item(OP_START, 4'd0);
        settle();

        // short timeout, scan and beat every tick or two: failures, recovery,
        // an untracked node adopted by its heartbeat
        program_regs(16'h8001, 20'd2, 16'd1, 16'd2);
        queue_item(OP_START, 4'd0);
        queue_item(OP_TICK, 4'd0);
        queue_item(OP_TICK, 4'd0);
        queue_item(OP_QUERY, 4'd0);
        queue_item(OP_HEARTBEAT, 4'd0);
        queue_item(OP_QUERY, 4'd0);
        queue_item(OP_HEARTBEAT, 4'd3);
        queue_item(OP_TICK, 4'd0);
        queue_item(OP_TICK, 4'd0);
        settle();

        // zero timeout and zero intervals: all sixteen nodes fail on one tick
        program_regs(16'hFFFF, 20'd0, 16'd0, 16'd0);
        queue_item(OP_START, 4'd0);
        queue_item(OP_QUERY, 4'd7);
        queue_item(OP_TICK, 4'd0);
        queue_item(OP_HEARTBEAT, 4'd9);
        settle();

        // largest intervals and a large timeout
        program_regs(16'h0000, 20'd1000000, 16'hFFFF, 16'hFFFF);
        queue_item(OP_TICK, 4'd0);
        queue_item(OP_QUERY, 4'd9);
        queue_item(OP_HEARTBEAT, 4'd2);
        queue_item(OP_QUERY, 4'd4);
        settle();

        // random phases with small timeouts so that failures keep happening
        for (int p = 0; p < 4; p++)
        begin
            to = ($urandom_range(0, 9) == 0) ? 20'd0 : TIMEOUT_W'($urandom_range(1, 12));
            program_regs(MASK_W'($urandom_range(0, 65535)), to,
                         PHASE_W'($urandom_range(0, 4)), PHASE_W'($urandom_range(0, 6)));
            steady = (p == 2);
            n_left = 52;
            while (n_left > 0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    queue_item(OP_START, NODE_W'($urandom_range(0, 15)));
                else if (pick < 28)
                    queue_item(OP_HEARTBEAT, NODE_W'($urandom_range(0, 15)));
                else if (pick < 50)
                    queue_item(OP_QUERY, NODE_W'($urandom_range(0, 15)));
                else if (pick < 60)
                begin
                    // run of ticks lets nodes age past the timeout
                    burst = $urandom_range(2, 8);
                    repeat (burst) queue_item(OP_TICK, NODE_W'($urandom_range(0, 15)));
                    n_left -= burst - 1;
                end
                else
                    queue_item(OP_TICK, NODE_W'($urandom_range(0, 15)));
                n_left--;
            end
            settle();
        end
        steady = 1'b0;

        repeat (NODES + 8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog for a hung handshake
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== heartbeat_failure_detector.f =====
rtl/hfd_pkg.sv
rtl/heartbeat_failure_detector.sv
tb/tb.sv
